[src/pus_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_pkg
// Shared types and constants of the page update sender.
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int unsigned PAGE_BYTES = 2048;
  localparam int CNT_W = $clog2(PAGE_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAGE_BYTES - 1);
  localparam logic [15:0] PAGE_LEN = 16'(PAGE_BYTES);
  localparam logic [31:0] PAGE_STRIDE = 32'(PAGE_BYTES);

  localparam logic [7:0] START_BYTE = 8'h99;
  localparam logic [7:0] SYNC_ACK   = 8'h88;
  localparam logic [7:0] PAGE_ACK   = 8'h77;
  localparam logic [7:0] FINISH_ACK = 8'h55;
  localparam logic [7:0] CTRL_CONT  = 8'h01;
  localparam logic [7:0] CTRL_END   = 8'h02;
  localparam logic [7:0] TRAILER    = 8'hFF;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_PCOUNT = 1'b1;

  localparam logic [31:0] BASE_RESET = 32'h0800_2000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [2:0] BEAT_LAST = 3'd7;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_POLL  = 2'd1,
    OP_RX    = 2'd2,
    OP_IMAGE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HANDSHAKE = 3'd1,
    PH_SENDING   = 3'd2,
    PH_ACK       = 3'd3,
    PH_FINISH    = 3'd4,
    PH_DONE      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_HEADER = 2'd2
  } cmd_kind_t;

  // One queued job for the back end: a single byte, a status word or a header.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [31:0] addr;
    logic [7:0]  page;
    logic        resend;
    phase_t      phase;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[src/pus_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_front
// Accepts input words, runs the download state and queues at most one job per item.
// ----------------------------------------------------------------------------
module pus_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  pus_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output pus_pkg::cmd_t       cmd
);

  pus_pkg::phase_t             phase_r, phase_nxt;
  logic [7:0]                  pidx_r, pidx_nxt;
  logic [pus_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [31:0]                 base_r;
  logic [7:0]                  pcount_r;

  pus_pkg::op_t op;
  logic         emit_byte, emit_status, emit_hdr, hdr_rs;
  logic [7:0]   byte_val;
  logic         accept;

  assign op        = pus_pkg::op_t'(in_tuser);
  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt   = phase_r;
    pidx_nxt    = pidx_r;
    cnt_nxt     = cnt_r;
    emit_byte   = 1'b0;
    emit_status = 1'b0;
    emit_hdr    = 1'b0;
    hdr_rs      = 1'b0;
    byte_val    = in_tdata;
    unique case (op)
      pus_pkg::OP_BEGIN: begin
        phase_nxt = pus_pkg::PH_HANDSHAKE;
        pidx_nxt  = '0;
        cnt_nxt   = '0;
        emit_byte = 1'b1;
        byte_val  = pus_pkg::START_BYTE;
      end
      pus_pkg::OP_POLL: begin
        if (phase_r == pus_pkg::PH_HANDSHAKE) begin
          emit_byte = 1'b1;
          byte_val  = pus_pkg::START_BYTE;
        end
      end
      pus_pkg::OP_RX: begin
        unique case (phase_r)
          pus_pkg::PH_HANDSHAKE: begin
            if (in_tdata == pus_pkg::SYNC_ACK) begin
              pidx_nxt = '0;
              if (pcount_r == '0) begin
                phase_nxt   = pus_pkg::PH_FINISH;
                emit_status = 1'b1;
              end else begin
                emit_hdr = 1'b1;
              end
            end
          end
          pus_pkg::PH_ACK: begin
            if (in_tdata == pus_pkg::PAGE_ACK) begin
              pidx_nxt = pidx_r + 8'd1;
              if (pidx_nxt < pcount_r) begin
                emit_hdr = 1'b1;
              end else begin
                phase_nxt   = pus_pkg::PH_FINISH;
                emit_status = 1'b1;
              end
            end else begin
              emit_hdr = 1'b1;
              hdr_rs   = 1'b1;
            end
          end
          pus_pkg::PH_FINISH: begin
            if (in_tdata == pus_pkg::FINISH_ACK) begin
              phase_nxt   = pus_pkg::PH_DONE;
              emit_status = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      pus_pkg::OP_IMAGE: begin
        if (phase_r == pus_pkg::PH_SENDING) begin
          emit_byte = 1'b1;
          if (cnt_r == pus_pkg::CNT_LAST) begin
            cnt_nxt   = '0;
            phase_nxt = pus_pkg::PH_ACK;
          end else begin
            cnt_nxt = cnt_r + (pus_pkg::CNT_W)'(1);
          end
        end
      end
      default: begin
      end
    endcase
    if (emit_hdr) begin
      phase_nxt = pus_pkg::PH_SENDING;
      cnt_nxt   = '0;
    end
  end

  // Job word for the back end; every result of the item carries the new phase.
  always_comb begin
    cmd        = '0;
    cmd.phase  = phase_nxt;
    cmd.resend = hdr_rs;
    cmd.page   = pidx_nxt;
    cmd.addr   = base_r + (32'(pidx_nxt) * pus_pkg::PAGE_STRIDE);
    if (emit_hdr) begin
      cmd.kind = pus_pkg::CMD_HEADER;
      cmd.data = (({1'b0, pidx_nxt} + 9'd1) < {1'b0, pcount_r}) ?
                 pus_pkg::CTRL_CONT : pus_pkg::CTRL_END;
    end else if (emit_status) begin
      cmd.kind = pus_pkg::CMD_STATUS;
      cmd.data = '0;
    end else begin
      cmd.kind = pus_pkg::CMD_BYTE;
      cmd.data = byte_val;
    end
  end

  assign push = accept && (emit_byte || emit_status || emit_hdr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pus_pkg::PH_IDLE;
      pidx_r   <= '0;
      cnt_r    <= '0;
      base_r   <= pus_pkg::BASE_RESET;
      pcount_r <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        pidx_r  <= pidx_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          pus_pkg::CFG_BASE:   base_r   <= cfg_wdata;
          pus_pkg::CFG_PCOUNT: pcount_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[src/pus_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_cmd_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pus_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pus_pkg::cmd_t       wr_cmd,
  input  logic                pop,
  output pus_pkg::cmd_t       head,
  output logic                head_valid,
  output pus_pkg::fifo_stat_t stat
);

  pus_pkg::cmd_t                mem [pus_pkg::FIFO_DEPTH];
  logic [pus_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pus_pkg::FIFO_AW:0]    count_r;

  assign stat.full  = (count_r == (pus_pkg::FIFO_AW + 1)'(pus_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_valid = !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + (pus_pkg::FIFO_AW)'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + (pus_pkg::FIFO_AW)'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (pus_pkg::FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (pus_pkg::FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

[src/pus_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_back
// Expands queued jobs into output words and holds them in the output register.
// ----------------------------------------------------------------------------
module pus_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pus_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [23:0]   out_tdata,
  output logic          out_tlast
);

  logic [2:0]  beat_r;
  logic        out_valid_r;
  logic [23:0] out_data_r, data_nxt;
  logic        out_last_r, last_nxt;
  logic        load;

  logic [7:0]  tx_byte;
  logic        tx_valid, fetch;
  logic [7:0]  fpage;
  logic        rs;

  assign load = head_valid && (!out_valid_r || out_tready);

  always_comb begin
    tx_byte  = '0;
    tx_valid = 1'b0;
    fetch    = 1'b0;
    fpage    = '0;
    rs       = 1'b0;
    last_nxt = 1'b1;
    unique case (head.kind)
      pus_pkg::CMD_BYTE: begin
        tx_byte  = head.data;
        tx_valid = 1'b1;
      end
      pus_pkg::CMD_HEADER: begin
        tx_valid = 1'b1;
        rs       = head.resend;
        last_nxt = (beat_r == pus_pkg::BEAT_LAST);
        // Header order: control, address high to low, length high, low, trailer.
        unique case (beat_r)
          3'd0: tx_byte = head.data;
          3'd1: tx_byte = head.addr[31:24];
          3'd2: tx_byte = head.addr[23:16];
          3'd3: tx_byte = head.addr[15:8];
          3'd4: tx_byte = head.addr[7:0];
          3'd5: tx_byte = pus_pkg::PAGE_LEN[15:8];
          3'd6: tx_byte = pus_pkg::PAGE_LEN[7:0];
          default: begin
            tx_byte = pus_pkg::TRAILER;
            fetch   = 1'b1;
            fpage   = head.page;
          end
        endcase
      end
      default: begin
      end
    endcase
    data_nxt = {2'b00, head.phase, rs, fpage, fetch, tx_valid, tx_byte};
  end

  assign pop = load && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        beat_r      <= last_nxt ? 3'd0 : beat_r + 3'd1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= data_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[src/page_update_sender.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_update_sender
// Host side of a paged firmware download: handshake, page headers, data relay.
// ----------------------------------------------------------------------------
// An input word is accepted every cycle while the four-entry job queue has
// room. A begin, poll, image byte or final status turns into one output word;
// a page header turns into eight words, issued one per cycle by the back end's
// beat counter while the output is ready; the front end keeps accepting into
// the queue meanwhile. An item is held in the job queue and then in the output
// register before its first word is valid. Reply bytes that cause no result
// are still accepted and update nothing downstream.
module page_update_sender (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // byte_value
  input  logic [1:0]  in_tuser,    // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte[7:0], tx_valid[8], fetch_request[9], fetch_page[17:10],
  // resend[18], phase[21:19], zero fill[23:22]
  output logic [23:0] out_tdata,
  output logic        out_tlast,   // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  pus_pkg::cmd_t       push_cmd, head;
  pus_pkg::fifo_stat_t fifo_stat;
  logic                push, pop, head_valid;

  pus_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  pus_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_cmd     (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .stat       (fifo_stat)
  );

  pus_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("job queue overflow");

  // The back end never takes a job from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("job queue underflow");

  // A word without a transmit byte is a status word and ends its item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[8]) |-> out_tlast)
    else $error("status word not marked last");

  // A fetch request only comes with the trailer byte that closes a header.
  a_fetch_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9]) |-> (out_tlast && out_tdata[7:0] == pus_pkg::TRAILER))
    else $error("fetch request outside header trailer");

endmodule

[sim/tb_page_update_sender.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_update_sender
// Self-checking bench for the paged firmware-download sender.
// ----------------------------------------------------------------------------
// Begin, poll, reply and image words go into the input stream. A behavioral
// copy of the download handshake predicts every transmit, status and header
// word, and the output stream is checked word by word in order. Both stream
// sides idle at random. One test holds the output off long enough for the
// job queue to fill and stall the input.
// ----------------------------------------------------------------------------
module tb_page_update_sender;

  // Same bit order as out_tdata[21:0], with tlast on top.
  typedef struct packed {
    logic            last;
    pus_pkg::phase_t phase;
    logic            resend;
    logic [7:0]      fetch_page;
    logic            fetch_request;
    logic            tx_valid;
    logic [7:0]      tx_byte;
  } tx_word_t;

  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // byte_value
  logic [1:0]  in_tuser;     // operation
  logic        out_tvalid;
  logic        out_tready;
  // tx_byte[7:0], tx_valid[8], fetch_request[9], fetch_page[17:10],
  // resend[18], phase[21:19], zero fill[23:22]
  logic [23:0] out_tdata;
  logic        out_tlast;    // last
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  // Predicted state of the sender and its registers.
  pus_pkg::phase_t pr_phase;
  logic [7:0]      pr_page;
  int unsigned     pr_count;
  logic [31:0]     pr_base;
  logic [7:0]      pr_pages;

  tx_word_t pending_tx[$];
  tx_word_t seen_word;
  tx_word_t want_word;
  int       mismatch_count;
  bit       quiet;
  bit       hold_req;
  int       hold_left;
  int       rdy_wait;

  page_update_sender u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic string word_text(tx_word_t w);
    return $sformatf("byte %h valid %b fetch %b page %h resend %b phase %0d last %b",
                     w.tx_byte, w.tx_valid, w.fetch_request, w.fetch_page, w.resend,
                     w.phase, w.last);
  endfunction

  function automatic void push_word(logic [7:0] tx_byte, logic tx_valid, logic fetch,
                                    logic [7:0] fetch_page, logic resend, logic last);
    tx_word_t w;
    w.tx_byte       = tx_byte;
    w.tx_valid      = tx_valid;
    w.fetch_request = fetch;
    w.fetch_page    = fetch_page;
    w.resend        = resend;
    w.phase         = pr_phase;
    w.last          = last;
    pending_tx.push_back(w);
  endfunction

  function automatic void push_page_header(logic resend);
    logic [31:0] addr;
    logic [7:0]  ctrl;
    addr = pr_base + {24'd0, pr_page} * pus_pkg::PAGE_STRIDE;
    ctrl = (int'(pr_page) + 1 < int'(pr_pages)) ? pus_pkg::CTRL_CONT : pus_pkg::CTRL_END;
    pr_phase = pus_pkg::PH_SENDING;
    pr_count = 0;
    push_word(ctrl,                   1'b1, 1'b0, 8'h00, resend, 1'b0);
    push_word(addr[31:24],            1'b1, 1'b0, 8'h00, resend, 1'b0);
    push_word(addr[23:16],            1'b1, 1'b0, 8'h00, resend, 1'b0);
    push_word(addr[15:8],             1'b1, 1'b0, 8'h00, resend, 1'b0);
    push_word(addr[7:0],              1'b1, 1'b0, 8'h00, resend, 1'b0);
    push_word(pus_pkg::PAGE_LEN[15:8], 1'b1, 1'b0, 8'h00, resend, 1'b0);
    push_word(pus_pkg::PAGE_LEN[7:0], 1'b1, 1'b0, 8'h00, resend, 1'b0);
    push_word(pus_pkg::TRAILER,       1'b1, 1'b1, pr_page, resend, 1'b1);
  endfunction

  function automatic void predict_tx_words(pus_pkg::op_t op, logic [7:0] b);
    case (op)
      pus_pkg::OP_BEGIN: begin
        pr_phase = pus_pkg::PH_HANDSHAKE;
        pr_page  = 8'h00;
        pr_count = 0;
        push_word(pus_pkg::START_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
      end
      pus_pkg::OP_POLL: begin
        if (pr_phase == pus_pkg::PH_HANDSHAKE) begin
          push_word(pus_pkg::START_BYTE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
        end
      end
      pus_pkg::OP_RX: begin
        if (pr_phase == pus_pkg::PH_HANDSHAKE) begin
          if (b == pus_pkg::SYNC_ACK) begin
            pr_page = 8'h00;
            if (pr_pages == 8'h00) begin
              pr_phase = pus_pkg::PH_FINISH;
              push_word(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
            end else begin
              push_page_header(1'b0);
            end
          end
        end else if (pr_phase == pus_pkg::PH_ACK) begin
          if (b == pus_pkg::PAGE_ACK) begin
            pr_page = pr_page + 8'd1;
            if (pr_page < pr_pages) begin
              push_page_header(1'b0);
            end else begin
              pr_phase = pus_pkg::PH_FINISH;
              push_word(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
            end
          end else begin
            push_page_header(1'b1);
          end
        end else if (pr_phase == pus_pkg::PH_FINISH && b == pus_pkg::FINISH_ACK) begin
          pr_phase = pus_pkg::PH_DONE;
          push_word(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
        end
      end
      default: begin
        if (pr_phase == pus_pkg::PH_SENDING) begin
          pr_count++;
          if (pr_count >= pus_pkg::PAGE_BYTES) begin
            pr_count = 0;
            pr_phase = pus_pkg::PH_ACK;
          end
          push_word(b, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  // Receiver side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rdy_wait > 0) begin
      rdy_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rdy_wait = quiet ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word = tx_word_t'({out_tlast, out_tdata[21:0]});
      if (pending_tx.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word: %s", word_text(seen_word));
      end else begin
        want_word = pending_tx.pop_front();
        if (seen_word.tx_byte !== want_word.tx_byte ||
            seen_word.tx_valid !== want_word.tx_valid ||
            seen_word.fetch_request !== want_word.fetch_request ||
            seen_word.fetch_page !== want_word.fetch_page ||
            seen_word.resend !== want_word.resend ||
            seen_word.phase !== want_word.phase ||
            seen_word.last !== want_word.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %s", word_text(want_word));
            $display("          got      %s", word_text(seen_word));
          end
        end
      end
    end
  end

  // Offers one word after an optional gap and holds it until it is taken.
  task automatic send_word(pus_pkg::op_t op, logic [7:0] b);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_tx_words(op, b);
  endtask

  // Waits for every predicted word, then lets the design settle with the input idle.
  task automatic wait_tx_drained();
    in_tvalid <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == pus_pkg::CFG_BASE) pr_base = value;
    else pr_pages = value[7:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Image bytes for the current page, with the odd ignored poll or reply mixed in.
  task automatic stream_image(int count);
    int k;
    k = 0;
    while (k < count && pr_phase == pus_pkg::PH_SENDING) begin
      if ($urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 1) == 1) send_word(pus_pkg::OP_POLL, rand_byte());
        else send_word(pus_pkg::OP_RX, rand_byte());
      end else begin
        send_word(pus_pkg::OP_IMAGE, rand_byte());
        k++;
      end
    end
  endtask

  // Reset register values: no pages, so the handshake ends in await finish.
  task automatic test_idle_and_handshake();
    send_word(pus_pkg::OP_POLL, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    send_word(pus_pkg::OP_IMAGE, 8'hFF);
    send_word(pus_pkg::OP_RX, pus_pkg::FINISH_ACK);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_POLL, 8'hFF);
    send_word(pus_pkg::OP_POLL, 8'h00);
    send_word(pus_pkg::OP_RX, 8'h00);
    send_word(pus_pkg::OP_RX, 8'hFF);
    send_word(pus_pkg::OP_RX, pus_pkg::PAGE_ACK);
    send_word(pus_pkg::OP_IMAGE, 8'hA5);
    send_word(pus_pkg::OP_BEGIN, 8'hFF);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    send_word(pus_pkg::OP_POLL, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    send_word(pus_pkg::OP_IMAGE, 8'h5A);
    send_word(pus_pkg::OP_RX, pus_pkg::FINISH_ACK);
    send_word(pus_pkg::OP_RX, pus_pkg::FINISH_ACK);
    send_word(pus_pkg::OP_POLL, 8'h00);
    send_word(pus_pkg::OP_IMAGE, 8'h00);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
  endtask

  // Two pages at the reset base address: the first header, part of its data
  // with ignored replies in between, and a restart in the middle of the page.
  task automatic test_page_headers();
    wait_tx_drained();
    write_reg(pus_pkg::CFG_PCOUNT, 32'd2);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    quiet = 1'b1;
    send_word(pus_pkg::OP_IMAGE, 8'h00);
    send_word(pus_pkg::OP_IMAGE, 8'hFF);
    stream_image(40);
    quiet = 1'b0;
    send_word(pus_pkg::OP_POLL, 8'h00);
    send_word(pus_pkg::OP_IMAGE, 8'h11);
    send_word(pus_pkg::OP_RX, 8'h3C);
    send_word(pus_pkg::OP_RX, pus_pkg::PAGE_ACK);
    stream_image(20);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    stream_image(10);
  endtask

  // Top base address, the largest page count, then a single page at zero.
  task automatic test_extreme_settings();
    wait_tx_drained();
    write_reg(pus_pkg::CFG_BASE, 32'hFFFF_FFFF);
    write_reg(pus_pkg::CFG_PCOUNT, 32'hFFFF_FFFF);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    stream_image(10);
    wait_tx_drained();
    write_reg(pus_pkg::CFG_BASE, 32'h0000_0000);
    write_reg(pus_pkg::CFG_PCOUNT, 32'd1);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    stream_image(10);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    stream_image(5);
  endtask

  // The output stalls for a long stretch while the bench keeps offering image bytes.
  task automatic test_output_stall();
    wait_tx_drained();
    write_reg(pus_pkg::CFG_PCOUNT, 32'd1);
    send_word(pus_pkg::OP_BEGIN, 8'h00);
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    quiet    = 1'b1;
    hold_req = 1'b1;
    stream_image(64);
    quiet = 1'b0;
    wait_tx_drained();
    stream_image(20);
  endtask

  task automatic test_random_noise();
    int k;
    logic [7:0] b;
    wait_tx_drained();
    write_reg(pus_pkg::CFG_BASE, $urandom);
    write_reg(pus_pkg::CFG_PCOUNT, 32'($urandom_range(0, 2)));
    for (k = 0; k < 100; k++) begin
      case ($urandom_range(0, 9))
        0: b = pus_pkg::START_BYTE;
        1: b = pus_pkg::SYNC_ACK;
        2: b = pus_pkg::PAGE_ACK;
        3: b = pus_pkg::FINISH_ACK;
        default: b = rand_byte();
      endcase
      send_word(pus_pkg::op_t'($urandom_range(0, 3)), b);
    end
  endtask

  // One download attempt: handshake, part of a page or the finish exchange.
  task automatic run_random_session();
    int pick;
    logic [7:0] pages;
    quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 1) begin
      wait_tx_drained();
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(pus_pkg::CFG_BASE, 32'h0000_0000);
      else if (pick == 1) write_reg(pus_pkg::CFG_BASE, 32'hFFFF_FFFF);
      else write_reg(pus_pkg::CFG_BASE, $urandom);
      pages = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 2));
      write_reg(pus_pkg::CFG_PCOUNT, {24'($urandom), pages});
    end
    send_word(pus_pkg::OP_BEGIN, rand_byte());
    repeat ($urandom_range(0, 3)) send_word(pus_pkg::OP_POLL, rand_byte());
    if ($urandom_range(0, 2) == 0) send_word(pus_pkg::OP_RX, rand_byte());
    if ($urandom_range(0, 3) == 0) send_word(pus_pkg::OP_IMAGE, rand_byte());
    send_word(pus_pkg::OP_RX, pus_pkg::SYNC_ACK);
    if (pr_phase == pus_pkg::PH_SENDING) begin
      // Part of the page; the next session restarts with a begin.
      stream_image($urandom_range(0, 30));
    end
    if (pr_phase == pus_pkg::PH_FINISH) begin
      if ($urandom_range(0, 1) == 1) send_word(pus_pkg::OP_RX, rand_byte());
      if ($urandom_range(0, 1) == 1) send_word(pus_pkg::OP_IMAGE, rand_byte());
      if ($urandom_range(0, 4) != 0) send_word(pus_pkg::OP_RX, pus_pkg::FINISH_ACK);
      if ($urandom_range(0, 1) == 1) send_word(pus_pkg::OP_RX, rand_byte());
    end
  endtask

  task automatic test_random_sessions();
    repeat (8) run_random_session();
    quiet = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    in_tuser       = pus_pkg::OP_BEGIN;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = pus_pkg::CFG_BASE;
    cfg_wdata      = 32'h0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    rdy_wait       = 0;
    mismatch_count = 0;
    pr_phase       = pus_pkg::PH_IDLE;
    pr_page        = 8'h00;
    pr_count       = 0;
    pr_base        = pus_pkg::BASE_RESET;
    pr_pages       = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_idle_and_handshake();
    test_page_headers();
    test_extreme_settings();
    test_output_stall();
    test_random_noise();
    test_random_sessions();
    wait_tx_drained();

    if (mismatch_count == 0 && pending_tx.size() == 0) begin
      $display("PASS page_update_sender");
    end else begin
      $display("FAIL page_update_sender");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL page_update_sender");
    $finish;
  end

endmodule
